// ===== hw/rtl/rsp_packet_framer_deframer_unit_defines.svh =====
// Assertion macros used by the packet framer/deframer RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef RSP_PACKET_FRAMER_DEFRAMER_UNIT_DEFINES_SVH
`define RSP_PACKET_FRAMER_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset
`define RFD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rfd: invariant violated");
// Antecedent at one edge implies consequent at the next edge
`define RFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfd: sequencing violated");
`else
`define RFD_ASSERT_ALWAYS(lbl, cond)
`define RFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rfd_pkg.sv =====
// Types, character constants and helpers for the packet framer/deframer.
// No dependencies.
`timescale 1ns / 1ps
package rfd_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_RX       = 2'd0,
        CMD_TX_BYTE  = 2'd1,
        CMD_TX_EMPTY = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_END  = 2'd1,
        KIND_INTR = 2'd2,
        KIND_WIRE = 2'd3
    } kind_t;

    // Receive phase
    typedef enum logic [1:0] {
        RX_HUNT  = 2'd0,
        RX_BODY  = 2'd1,
        RX_CSUM1 = 2'd2,
        RX_CSUM2 = 2'd3
    } rx_phase_t;

    // Configuration register indexes
    localparam logic CFG_NOACK  = 1'b0;
    localparam logic CFG_MAXLEN = 1'b1;

    localparam logic [15:0] MAXLEN_RESET = 16'd20479;

    // Protocol characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_INTR  = 8'h03;
    localparam logic [7:0] CH_ACK   = 8'h2B;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [15:0] body_length;
        logic        send_ack;
    } result_t;

    // Results caused by one input transfer
    typedef struct packed {
        logic [CNT_W-1:0]                n;
        result_t [MAX_RESULTS-1:0]       r;
    } result_list_t;

    // Lower-case hex character for one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = 8'h30 + {4'd0, v};
        else
            d = 8'h57 + {4'd0, v};
        return d;
    endfunction

    function automatic result_t mk_result(input kind_t k, input logic [7:0] b,
                                          input logic [15:0] len, input logic ack);
        result_t res;
        res.kind        = k;
        res.out_byte    = b;
        res.body_length = len;
        res.send_ack    = ack;
        return res;
    endfunction

endpackage

// ===== hw/rtl/rsp_packet_framer_deframer_unit.sv =====
// Top level of the debugger serial-protocol packet framer/deframer.
// Depends on rfd_pkg, rfd_engine and rfd_out_queue.
//
//  Channel  Signals                                        Direction
//  in       in_valid/in_ready, cmd, data_byte, is_last     to block
//  out      out_valid/out_ready, kind, out_byte,
//           body_length, send_ack, last                    from block
//  cfg      cfg_we, cfg_addr, cfg_wdata                    to block, write only
//
// An input transfer is processed combinationally; its results (0 to 5) are
// registered and leave one per cycle while out_ready is high.
// The next input is taken in the cycle the last pending result is transferred.
// Reset (rst_n low, asynchronous) empties the result buffer and clears state.
// A stalled output holds the current result and blocks further input.
`timescale 1ns / 1ps
module rsp_packet_framer_deframer_unit
    import rfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [15:0] body_length,
    output logic        send_ack,
    output logic        last
);

    result_list_t lst;
    result_t      cur;
    logic         fire;

    assign fire = in_valid && in_ready;

    rfd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .cmd       (cmd),
        .data_byte (data_byte),
        .is_last   (is_last),
        .lst       (lst)
    );

    rfd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .lst       (lst),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cur       (cur),
        .cur_last  (last)
    );

    // Result fields
    assign kind        = cur.kind;
    assign out_byte    = cur.out_byte;
    assign body_length = cur.body_length;
    assign send_ack    = cur.send_ack;

endmodule

// ===== hw/rtl/rfd_engine.sv =====
// Framing state, configuration registers and per-transfer result generation.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
module rfd_engine
    import rfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         fire,
    input  logic [1:0]   cmd,
    input  logic [7:0]   data_byte,
    input  logic         is_last,
    output result_list_t lst
);

    logic        noack_reg;
    logic [15:0] max_len_reg;
    rx_phase_t   rx_phase_reg, rx_phase_next;
    logic [15:0] rx_count_reg, rx_count_next;
    logic        tx_open_reg, tx_open_next;
    logic [7:0]  tx_sum_reg, tx_sum_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noack_reg   <= 1'b0;
            max_len_reg <= MAXLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_NOACK:  noack_reg   <= cfg_wdata[0];
                CFG_MAXLEN: max_len_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Next state and result list for the presented item
    always_comb
    begin
        logic [CNT_W-1:0] k;
        logic [7:0]       base_sum;
        logic [7:0]       close_sum;
        lst           = '0;
        k             = '0;
        rx_phase_next = rx_phase_reg;
        rx_count_next = rx_count_reg;
        tx_open_next  = tx_open_reg;
        tx_sum_next   = tx_sum_reg;
        base_sum      = tx_open_reg ? tx_sum_reg : 8'd0;
        close_sum     = base_sum;
        case (cmd_t'(cmd))
            CMD_RX:
            begin
                case (rx_phase_reg)
                    RX_HUNT:
                    begin
                        if (data_byte == CH_START)
                        begin
                            rx_phase_next = RX_BODY;
                            rx_count_next = 16'd0;
                        end
                        else if (data_byte == CH_INTR)
                        begin
                            lst.r[k] = mk_result(KIND_INTR, 8'd0, 16'd0, 1'b0);
                            k        = k + 1'b1;
                        end
                    end
                    RX_BODY:
                    begin
                        if (data_byte == CH_HASH)
                            rx_phase_next = RX_CSUM1;
                        else if (rx_count_reg < max_len_reg)
                        begin
                            lst.r[k]      = mk_result(KIND_BODY, data_byte, 16'd0, 1'b0);
                            k             = k + 1'b1;
                            rx_count_next = rx_count_reg + 16'd1;
                        end
                    end
                    RX_CSUM1:
                        rx_phase_next = RX_CSUM2;
                    default:
                    begin
                        // second checksum digit: packet complete
                        rx_phase_next = RX_HUNT;
                        lst.r[k] = mk_result(KIND_END, noack_reg ? 8'd0 : CH_ACK,
                                             rx_count_reg, !noack_reg);
                        k        = k + 1'b1;
                    end
                endcase
            end
            CMD_TX_BYTE:
            begin
                if (!tx_open_reg)
                begin
                    lst.r[k] = mk_result(KIND_WIRE, CH_START, 16'd0, 1'b0);
                    k        = k + 1'b1;
                end
                lst.r[k]     = mk_result(KIND_WIRE, data_byte, 16'd0, 1'b0);
                k            = k + 1'b1;
                close_sum    = base_sum + data_byte;
                tx_open_next = 1'b1;
                tx_sum_next  = close_sum;
                if (is_last)
                begin
                    lst.r[k]     = mk_result(KIND_WIRE, CH_HASH, 16'd0, 1'b0);
                    k            = k + 1'b1;
                    lst.r[k]     = mk_result(KIND_WIRE, hex_digit(close_sum[7:4]),
                                             16'd0, 1'b0);
                    k            = k + 1'b1;
                    lst.r[k]     = mk_result(KIND_WIRE, hex_digit(close_sum[3:0]),
                                             16'd0, 1'b0);
                    k            = k + 1'b1;
                    tx_open_next = 1'b0;
                    tx_sum_next  = 8'd0;
                end
            end
            CMD_TX_EMPTY:
            begin
                // opens a packet if none is open, then closes it
                if (!tx_open_reg)
                begin
                    lst.r[k] = mk_result(KIND_WIRE, CH_START, 16'd0, 1'b0);
                    k        = k + 1'b1;
                end
                lst.r[k]     = mk_result(KIND_WIRE, CH_HASH, 16'd0, 1'b0);
                k            = k + 1'b1;
                lst.r[k]     = mk_result(KIND_WIRE, hex_digit(close_sum[7:4]), 16'd0, 1'b0);
                k            = k + 1'b1;
                lst.r[k]     = mk_result(KIND_WIRE, hex_digit(close_sum[3:0]), 16'd0, 1'b0);
                k            = k + 1'b1;
                tx_open_next = 1'b0;
                tx_sum_next  = 8'd0;
            end
            default:
                ;
        endcase
        lst.n = k;
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase_reg <= RX_HUNT;
            rx_count_reg <= 16'd0;
            tx_open_reg  <= 1'b0;
            tx_sum_reg   <= 8'd0;
        end
        else if (fire)
        begin
            rx_phase_reg <= rx_phase_next;
            rx_count_reg <= rx_count_next;
            tx_open_reg  <= tx_open_next;
            tx_sum_reg   <= tx_sum_next;
        end
    end

endmodule

// ===== hw/rtl/rfd_out_queue.sv =====
// Result buffer: holds the results of one transfer and presents them in order.
// Depends on rfd_pkg and rsp_packet_framer_deframer_unit_defines.svh.
`timescale 1ns / 1ps
`include "rsp_packet_framer_deframer_unit_defines.svh"
module rfd_out_queue
    import rfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_list_t lst,
    output logic         can_load,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      cur,
    output logic         cur_last
);

    result_t [MAX_RESULTS-1:0] buf_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      out_xfer;

    // Presentation and load permission
    assign out_valid = (cnt_reg != '0);
    assign cur_last  = (CNT_W'(idx_reg) == cnt_reg - 1'b1);
    assign cur       = buf_reg[idx_reg];
    assign out_xfer  = out_valid && out_ready;
    assign can_load  = !out_valid || (out_xfer && cur_last);

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= lst.r;
    end

    // Count and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= lst.n;
            idx_reg <= '0;
        end
        else if (out_xfer)
        begin
            if (cur_last)
            begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    `RFD_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= CNT_W'(MAX_RESULTS))
    `RFD_ASSERT_ALWAYS(a_idx_in_cnt, !out_valid || (CNT_W'(idx_reg) < cnt_reg))
    `RFD_ASSERT_ALWAYS(a_no_overwrite, !load || can_load)
    `RFD_ASSERT_NEXT(a_load_shows, load && (lst.n != '0), out_valid && (idx_reg == '0))

endmodule

// ===== tb/tb_rsp_packet_framer_deframer_unit.sv =====
// Self-checking testbench for rsp_packet_framer_deframer_unit: directed and random
// receive/transmit byte streams, checked against an in-bench framing predictor.
// Depends on rfd_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_rsp_packet_framer_deframer_unit;
    import rfd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int MAX_REPORTED    = 10;
    localparam logic [127:0] HEX_CHARS = "0123456789abcdef";

    // One byte command offered on the input channel
    typedef struct packed {
        cmd_t       op;
        logic [7:0] value;
        logic       fin;
    } byte_cmd_t;

    // One framing result as it should leave the block
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_val;
        logic [15:0] len;
        logic        ack;
        logic        last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = 2'd0;
    logic [7:0]  data_byte = 8'd0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] body_length;
    logic        send_ack;
    logic        last;

    byte_cmd_t     pending_bytes[$];
    frame_result_t expected_frames[$];
    frame_result_t step_frames[$];

    // Predictor copy of the framing state and registers
    rx_phase_t   rx_state = RX_HUNT;
    logic [15:0] rx_kept = 16'd0;
    logic        tx_pkt_open = 1'b0;
    logic [7:0]  tx_csum = 8'd0;
    logic        cfg_noack = 1'b0;
    logic [15:0] cfg_max_body = MAXLEN_RESET;

    int fail_count = 0;
    int items_queued = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    rsp_packet_framer_deframer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .out_byte    (out_byte),
        .body_length (body_length),
        .send_ack    (send_ack),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_CHARS[(15 - int'(nib)) * 8 +: 8];
    endfunction

    task automatic add_frame(input kind_t k, input logic [7:0] b, input logic [15:0] n,
                             input logic a);
        frame_result_t f;
        f.kind     = k;
        f.byte_val = b;
        f.len      = n;
        f.ack      = a;
        f.last     = 1'b0;
        step_frames.push_back(f);
    endtask

    // '#' then the two checksum digits; the outgoing packet is then closed
    task automatic close_tx_packet;
        add_frame(KIND_WIRE, CH_HASH, 16'd0, 1'b0);
        add_frame(KIND_WIRE, hex_char(tx_csum[7:4]), 16'd0, 1'b0);
        add_frame(KIND_WIRE, hex_char(tx_csum[3:0]), 16'd0, 1'b0);
        tx_pkt_open = 1'b0;
        tx_csum     = 8'd0;
    endtask

    task automatic open_tx_packet;
        if (!tx_pkt_open)
        begin
            add_frame(KIND_WIRE, CH_START, 16'd0, 1'b0);
            tx_pkt_open = 1'b1;
            tx_csum     = 8'd0;
        end
    endtask

    // Work out the results of one accepted byte command
    task automatic predict_transfer(input cmd_t c, input logic [7:0] b, input logic fin);
        frame_result_t f;
        int i;
        step_frames.delete();
        case (c)
            CMD_RX:
            begin
                case (rx_state)
                    RX_HUNT:
                    begin
                        if (b == CH_START)
                        begin
                            rx_state = RX_BODY;
                            rx_kept  = 16'd0;
                        end
                        else if (b == CH_INTR)
                            add_frame(KIND_INTR, 8'd0, 16'd0, 1'b0);
                    end
                    RX_BODY:
                    begin
                        if (b == CH_HASH)
                            rx_state = RX_CSUM1;
                        else if (rx_kept < cfg_max_body)
                        begin
                            add_frame(KIND_BODY, b, 16'd0, 1'b0);
                            rx_kept = rx_kept + 16'd1;
                        end
                    end
                    RX_CSUM1:
                        rx_state = RX_CSUM2;
                    default:
                    begin
                        rx_state = RX_HUNT;
                        if (cfg_noack)
                            add_frame(KIND_END, 8'd0, rx_kept, 1'b0);
                        else
                            add_frame(KIND_END, CH_ACK, rx_kept, 1'b1);
                    end
                endcase
            end
            CMD_TX_BYTE:
            begin
                open_tx_packet();
                add_frame(KIND_WIRE, b, 16'd0, 1'b0);
                tx_csum = tx_csum + b;
                if (fin)
                    close_tx_packet();
            end
            CMD_TX_EMPTY:
            begin
                open_tx_packet();
                close_tx_packet();
            end
            default: ;
        endcase
        for (i = 0; i < step_frames.size(); i++)
        begin
            f      = step_frames[i];
            f.last = (i == step_frames.size() - 1);
            expected_frames.push_back(f);
        end
    endtask

    // Input driver: a new transfer is offered once the previous one has gone
    always @(posedge clk)
    begin : drive_inputs
        byte_cmd_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predict_transfer(cmd_t'(cmd), data_byte, is_last);
            if (!in_valid || in_ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= nxt.op;
                    data_byte <= nxt.value;
                    is_last   <= nxt.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin : drive_ready
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left    <= hold_request;
            hold_request = 0;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor: each transfer against the oldest expectation
    always @(posedge clk)
    begin : check_results
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_frames.size() == 0)
                log_failure($sformatf("unexpected result kind %0d byte %02h len %0d ack %0b last %0b",
                                      kind, out_byte, body_length, send_ack, last));
            else
            begin
                want = expected_frames.pop_front();
                if (kind !== want.kind || out_byte !== want.byte_val
                    || body_length !== want.len || send_ack !== want.ack
                    || last !== want.last)
                    log_failure($sformatf({"exp kind %0d byte %02h len %0d ack %0b last %0b, ",
                                           "got kind %0d byte %02h len %0d ack %0b last %0b"},
                                          want.kind, want.byte_val, want.len, want.ack,
                                          want.last, kind, out_byte, body_length, send_ack,
                                          last));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input cmd_t c, input logic [7:0] b, input logic fin);
        byte_cmd_t it;
        it.op    = c;
        it.value = b;
        it.fin   = fin;
        pending_bytes.push_back(it);
        if (c != CMD_NONE)
            items_queued++;
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NOACK)
            cfg_noack = val[0];
        else
            cfg_max_body = val;
    endtask

    task automatic set_regs(input logic noack, input logic [15:0] max_len);
        write_reg(CFG_NOACK, {15'd0, noack});
        write_reg(CFG_MAXLEN, max_len);
    endtask

    // Wait until every queued byte is taken and every result has come back
    task automatic wait_drained;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly whole packets in both directions, with some noise and broken packets
    task automatic random_traffic(input int count);
        int target;
        int pick;
        int n;
        int i;
        logic [7:0] b;
        target = items_queued + count;
        while (items_queued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                // well-formed received packet, checksum digits not verified
                n = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(40);
                push_item(CMD_RX, CH_START, 1'($urandom_range(1)));
                for (i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(255));
                    if (b == CH_HASH)
                        b = b ^ 8'h80;
                    push_item(CMD_RX, b, 1'($urandom_range(1)));
                end
                push_item(CMD_RX, CH_HASH, 1'($urandom_range(1)));
                push_item(CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
                push_item(CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (pick < 45)
                push_item(CMD_RX, CH_INTR, 1'($urandom_range(1)));
            else if (pick < 75)
            begin
                n = 1 + $urandom_range(5);
                for (i = 0; i < n; i++)
                    push_item(CMD_TX_BYTE, 8'($urandom_range(255)), i == n - 1);
            end
            else if (pick < 83)
            begin
                // open packet (possibly none) closed by the empty command
                n = $urandom_range(3);
                for (i = 0; i < n; i++)
                    push_item(CMD_TX_BYTE, 8'($urandom_range(255)), 1'b0);
                push_item(CMD_TX_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (pick < 90)
            begin
                // truncated packet: start and a few bytes, no terminator
                n = $urandom_range(4);
                push_item(CMD_RX, CH_START, 1'($urandom_range(1)));
                for (i = 0; i < n; i++)
                    push_item(CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            else if (pick < 95)
                push_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                push_item(CMD_RX, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin : run_phases
        frame_result_t left;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset register values
        send_idle_pct = 11;
        recv_idle_pct = 63;
        push_item(CMD_RX, 8'h00, 1'b0);
        push_item(CMD_RX, CH_INTR, 1'b1);
        push_item(CMD_RX, CH_START, 1'b0);
        push_item(CMD_RX, 8'hFF, 1'b1);
        push_item(CMD_RX, 8'h00, 1'b0);
        push_item(CMD_RX, CH_START, 1'b0);
        push_item(CMD_RX, CH_INTR, 1'b0);
        push_item(CMD_RX, CH_HASH, 1'b0);
        push_item(CMD_RX, 8'h61, 1'b0);
        push_item(CMD_RX, 8'h62, 1'b1);
        push_item(CMD_TX_BYTE, 8'hFF, 1'b0);
        push_item(CMD_TX_BYTE, 8'h01, 1'b1);
        push_item(CMD_TX_EMPTY, 8'h00, 1'b0);
        push_item(CMD_TX_BYTE, 8'hAB, 1'b0);
        push_item(CMD_TX_EMPTY, 8'hFF, 1'b1);
        push_item(CMD_NONE, 8'hFF, 1'b1);
        push_item(CMD_RX, 8'hFF, 1'b1);
        wait_drained();

        // Limit of one body byte, no acknowledge
        set_regs(1'b1, 16'd1);
        random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        // Largest limit; receiver holds off while the sender keeps offering
        set_regs(1'b0, 16'hFFFF);
        random_traffic(ITEMS_PER_PHASE);
        @(negedge clk);
        hold_request = HOLD_OFF_CYCLES;
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 11;

        // Zero limit keeps no body bytes at all
        set_regs(1'b1, 16'd0);
        random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        // Sender pauses halfway until every result is back
        set_regs(1'b0, 16'd3);
        random_traffic(ITEMS_PER_PHASE / 2);
        wait_drained();
        random_traffic(ITEMS_PER_PHASE / 2);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(1'b1, MAXLEN_RESET);
        random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        while (expected_frames.size() > 0)
        begin
            left = expected_frames.pop_front();
            log_failure($sformatf("missing result kind %0d byte %02h len %0d ack %0b last %0b",
                                  left.kind, left.byte_val, left.len, left.ack, left.last));
        end
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
